FILE: design/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: design/lkvc_pkg.sv
`timescale 1ns / 1ps

package lkvc_pkg;

  localparam int VALUE_BITS = 32;

  localparam logic [VALUE_BITS-1:0] MISS_VALUE = '1;
  localparam logic [VALUE_BITS-1:0] PUT_VALUE  = '0;

  typedef enum logic {
    ACT_GET = 1'b0,
    ACT_PUT = 1'b1
  } action_t;

  // Update command broadcast from the controller to every cell.
  typedef struct packed {
    logic upd;     // apply the update this cycle
    logic is_put;  // item is a put
    logic hit;     // some cell matched the key
    logic full;    // every cell holds a valid entry
  } lkvc_ctrl_t;

endpackage

FILE: design/lru_key_value_cache_core.sv
`timescale 1ns / 1ps
// Fully associative LRU key/value store built as a row of ENTRIES cells.
// Input channel: an item (in_action, in_key, in_put_value) transfers at a
//   rising edge with start high and busy low. Only the low KEY_BITS bits of
//   in_key are compared and stored.
// Result channel: exactly one result per item, shown on out_hit,
//   out_read_value and out_evicted for one cycle while out_strobe is high.
//   The receiver cannot stall; each result must be taken in that cycle.
// Timing: at the accept edge every cell compares its key with in_key. In
//   the next cycle (busy high) the matches are reduced, each cell updates
//   its recency rank and the fill/evict chain picks a slot; the result
//   strobes in the cycle after that. Busy keeps a new item out during the
//   update cycle, set by the compare-then-update pair of each cell; the
//   next item may be accepted while the previous result strobes.
// Reset (rst_n low, synchronous): all slots empty, no item in flight. No
//   clearing pass is needed; keys and values are only read under valid.
module lru_key_value_cache_core #(
  parameter int ENTRIES  = 8,
  parameter int KEY_BITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_action,
  input  logic [63:0]        in_key,
  input  logic signed [31:0] in_put_value,
  output logic               out_strobe,
  output logic               out_hit,
  output logic signed [31:0] out_read_value,
  output logic               out_evicted
);

  localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int VB = lkvc_pkg::VALUE_BITS;

  // Control.
  logic phase_r;       // update cycle of the item in flight
  logic out_strobe_r;
  logic acc;

  // Item held for the update cycle.
  logic                is_put_r;
  logic [KEY_BITS-1:0] key_r;
  logic [VB-1:0]       put_value_r;

  // Result registers.
  logic          hit_r;
  logic [VB-1:0] read_value_r;
  logic          evicted_r;

  // Per-cell taps.
  logic          cell_match [ENTRIES];
  logic [RW-1:0] cell_rank  [ENTRIES];
  logic [VB-1:0] cell_value [ENTRIES];
  logic          free_chain [ENTRIES];  // free_chain[i]: some cell 0..i is free
  logic          cell_free_in [ENTRIES];

  logic               any_hit;
  logic [ENTRIES-1:0] match_vec;
  logic [RW-1:0]      hit_rank;
  logic [VB-1:0]      hit_value;
  logic               full;
  lkvc_pkg::lkvc_ctrl_t ctrl;

  assign acc  = start && !phase_r;
  assign busy = phase_r;
  // The end of the free chain tells whether any cell is still empty.
  assign full = !free_chain[ENTRIES-1];

  // Matches are one-hot, so a masked OR selects the hit cell's rank and value.
  always_comb begin
    any_hit   = 1'b0;
    match_vec = '0;
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      any_hit      = any_hit | cell_match[i];
      match_vec[i] = cell_match[i];
      hit_rank     = hit_rank | (cell_rank[i] & {RW{cell_match[i]}});
      hit_value    = hit_value | (cell_value[i] & {VB{cell_match[i]}});
    end
  end

  always_comb begin
    ctrl.upd    = phase_r;
    ctrl.is_put = is_put_r;
    ctrl.hit    = any_hit;
    ctrl.full   = full;
  end

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_head
        assign cell_free_in[g] = 1'b0;
      end else begin : g_link
        assign cell_free_in[g] = free_chain[g-1];
      end

      lkvc_cell #(
        .KEY_BITS  (KEY_BITS),
        .RANK_BITS (RW),
        .LAST_RANK (ENTRIES - 1)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .acc      (acc),
        .cmp_key  (in_key[KEY_BITS-1:0]),
        .wr_key   (key_r),
        .wr_value (put_value_r),
        .ctrl     (ctrl),
        .hit_rank (hit_rank),
        .free_in  (cell_free_in[g]),
        .free_out (free_chain[g]),
        .match    (cell_match[g]),
        .rank     (cell_rank[g]),
        .value    (cell_value[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      phase_r      <= acc;
      out_strobe_r <= phase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      is_put_r    <= (lkvc_pkg::action_t'(in_action) == lkvc_pkg::ACT_PUT);
      key_r       <= in_key[KEY_BITS-1:0];
      put_value_r <= in_put_value;
    end
    if (phase_r) begin
      hit_r <= any_hit;
      if (is_put_r) begin
        read_value_r <= lkvc_pkg::PUT_VALUE;
      end else begin
        read_value_r <= any_hit ? hit_value : lkvc_pkg::MISS_VALUE;
      end
      evicted_r <= is_put_r && !any_hit && full;
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_hit        = hit_r;
  assign out_read_value = read_value_r;
  assign out_evicted    = evicted_r;

`include "assert_macros.svh"

  // An accepted item goes straight to its update cycle, then to its result.
  `ASSERT_NXT(a_acc_to_upd, clk, rst_n, start && !busy, busy)
  `ASSERT_NXT(a_upd_to_out, clk, rst_n, busy, out_strobe && !busy)
  // Eviction only happens on a put of a new key.
  `ASSERT_IMP(a_evict_miss, clk, rst_n, out_strobe && out_evicted,
              !out_hit && out_read_value == 32'sd0)
  // At most one cell can match a key.
  `ASSERT_IMP(a_match_onehot, clk, rst_n, busy, $onehot0(match_vec))

endmodule

FILE: design/lkvc_cell.sv
`timescale 1ns / 1ps

module lkvc_cell #(
  parameter int KEY_BITS  = 64,
  parameter int RANK_BITS = 3,
  parameter int LAST_RANK = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          acc,
  input  logic [KEY_BITS-1:0]           cmp_key,
  input  logic [KEY_BITS-1:0]           wr_key,
  input  logic [lkvc_pkg::VALUE_BITS-1:0] wr_value,
  input  lkvc_pkg::lkvc_ctrl_t          ctrl,
  input  logic [RANK_BITS-1:0]          hit_rank,
  input  logic                          free_in,
  output logic                          free_out,
  output logic                          match,
  output logic [RANK_BITS-1:0]          rank,
  output logic [lkvc_pkg::VALUE_BITS-1:0] value
);

  logic                            valid_r;
  logic [RANK_BITS-1:0]            rank_r;
  logic                            match_r;
  logic [KEY_BITS-1:0]             key_r;
  logic [lkvc_pkg::VALUE_BITS-1:0] value_r;
  logic                            target;

  // Lowest free cell takes a new key; in a full row the oldest one does.
  assign target   = ctrl.full ? (rank_r == RANK_BITS'(LAST_RANK)) : (!valid_r && !free_in);
  assign free_out = free_in || !valid_r;
  assign match    = match_r;
  assign rank     = rank_r;
  assign value    = value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
      match_r <= 1'b0;
    end else begin
      if (acc) begin
        match_r <= valid_r && (key_r == cmp_key);
      end
      if (ctrl.upd) begin
        if (ctrl.hit) begin
          if (match_r) begin
            rank_r <= '0;
          end else if (valid_r && (rank_r < hit_rank)) begin
            rank_r <= rank_r + RANK_BITS'(1);
          end
        end else if (ctrl.is_put) begin
          if (target) begin
            valid_r <= 1'b1;
            rank_r  <= '0;
          end else if (valid_r) begin
            rank_r <= rank_r + RANK_BITS'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.upd && ctrl.is_put && (ctrl.hit ? match_r : target)) begin
      value_r <= wr_value;
      if (!ctrl.hit) begin
        key_r <= wr_key;
      end
    end
  end

endmodule
